/* rtl/kmr_pkg.sv */
// Shared types, constants and codes of the keyboard meta layer remapper.
package kmr_pkg;

   localparam int KEYMAP_DEPTH = 256;
   localparam int KEYMAP_AW    = (KEYMAP_DEPTH > 1) ? $clog2(KEYMAP_DEPTH) : 1;
   localparam int MAX_REPORTS  = 10;
   localparam int RUN_CW       = $clog2(MAX_REPORTS + 1);

   // operations
   localparam logic [1:0] OP_KEY    = 2'd0;
   localparam logic [1:0] OP_MOTION = 2'd1;
   localparam logic [1:0] OP_WRITE  = 2'd2;

   // key states
   localparam logic [1:0] ST_PRESSED  = 2'd1;
   localparam logic [1:0] ST_RELEASED = 2'd3;

   // report kinds
   localparam logic [1:0] RK_KEY   = 2'd0;
   localparam logic [1:0] RK_SCAN  = 2'd1;
   localparam logic [1:0] RK_LIGHT = 2'd2;
   localparam logic [1:0] RK_TOUCH = 2'd3;

   // register indexes
   localparam logic CSR_ARROWS = 1'b0;
   localparam logic CSR_STEP   = 1'b1;

   // key codes
   localparam logic [7:0] K_ESC = 8'd1, K_TAB = 8'd15, K_Q = 8'd16, K_W = 8'd17;
   localparam logic [7:0] K_E = 8'd18, K_R = 8'd19, K_T = 8'd20, K_O = 8'd24;
   localparam logic [7:0] K_P = 8'd25, K_LCTRL = 8'd29, K_A = 8'd30, K_S = 8'd31;
   localparam logic [7:0] K_D = 8'd32, K_F = 8'd33, K_LSHIFT = 8'd42, K_X = 8'd45;
   localparam logic [7:0] K_C = 8'd46, K_N = 8'd49, K_M = 8'd50, K_LALT = 8'd56;
   localparam logic [7:0] K_RALT = 8'd100, K_HOME = 8'd102, K_UP = 8'd103;
   localparam logic [7:0] K_PGUP = 8'd104, K_LEFT = 8'd105, K_RIGHT = 8'd106;
   localparam logic [7:0] K_END = 8'd107, K_DOWN = 8'd108, K_PGDN = 8'd109;
   localparam logic [7:0] K_MUTE = 8'd113, K_COMPOSE = 8'd127, K_PROPS = 8'd130;
   localparam logic [7:0] K_ENTER = 8'd28, K_UNKNOWN = 8'd240, K_PREFIX = 8'd162;
   localparam logic [7:0] LEVEL_MAX = 8'hff;
   localparam logic signed [7:0] MOTION_DEAD = 8'sd4;

   typedef struct packed {
      logic [1:0]        operation;
      logic [1:0]        key_phase;
      logic [7:0]        scancode;
      logic              shift_held;
      logic              ctrl_held;
      logic              altgr_held;
      logic signed [7:0] motion_x;
      logic signed [7:0] motion_y;
      logic              in_range;
   } item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] code;
      logic [7:0] value;
   } report_type;

   typedef struct packed {
      report_type [MAX_REPORTS-1:0] reports;
      logic [RUN_CW-1:0]            count;
   } run_type;

   function automatic report_type mk_report(input logic [1:0] kind,
                                            input logic [7:0] code,
                                            input logic [7:0] value);
      report_type r;
      r.kind  = kind;
      r.code  = code;
      r.value = value;
      return r;
   endfunction

endpackage

/* rtl/kmr_if.sv */
// Channel interfaces: event requests, reports and register writes.
interface kmr_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [1:0]        key_phase;
   logic [7:0]        scancode;
   logic              shift_held;
   logic              ctrl_held;
   logic              altgr_held;
   logic signed [7:0] motion_x;
   logic signed [7:0] motion_y;
   logic [7:0]        map_entry;
   modport source (output valid, operation, key_phase, scancode, shift_held, ctrl_held,
                   altgr_held, motion_x, motion_y, map_entry, input ready);
   modport sink (input valid, operation, key_phase, scancode, shift_held, ctrl_held,
                 altgr_held, motion_x, motion_y, map_entry, output ready);
endinterface

interface kmr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] report_kind;
   logic [7:0] report_code;
   logic [7:0] report_value;
   logic       run_end;
   modport source (output valid, report_kind, report_code, report_value, run_end,
                   input ready);
   modport sink (input valid, report_kind, report_code, report_value, run_end,
                 output ready);
endinterface

interface kmr_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/kmr_front.sv */
// Input register and keymap table memory.
module kmr_front (
   input  logic                clock,
   input  logic                reset,
   kmr_req_if.sink             req_ch,
   input  logic                take,
   output logic                item_valid,
   output kmr_pkg::item_type   item,
   output logic [7:0]          key_code
);
   import kmr_pkg::*;

   logic [7:0]          keymap [KEYMAP_DEPTH];
   logic                valid_ff, valid_in;
   item_type            item_ff;
   logic [7:0]          code_ff;
   logic                accept, in_range;
   logic [KEYMAP_AW-1:0] addr;

   assign req_ch.ready = !valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_range     = {1'b0, req_ch.scancode} < 9'(KEYMAP_DEPTH);
   assign addr         = req_ch.scancode[KEYMAP_AW-1:0];
   assign valid_in     = accept ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // table write and registered read, both at accept
   always_ff @(posedge clock) begin
      if (accept && req_ch.operation == OP_WRITE && in_range) begin
         keymap[addr] <= req_ch.map_entry;
      end
      if (accept) begin
         code_ff <= keymap[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.operation  <= req_ch.operation;
         item_ff.key_phase  <= req_ch.key_phase;
         item_ff.scancode   <= req_ch.scancode;
         item_ff.shift_held <= req_ch.shift_held;
         item_ff.ctrl_held  <= req_ch.ctrl_held;
         item_ff.altgr_held <= req_ch.altgr_held;
         item_ff.motion_x   <= req_ch.motion_x;
         item_ff.motion_y   <= req_ch.motion_y;
         item_ff.in_range   <= in_range;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
   assign key_code   = item_ff.in_range ? code_ff : 8'd0;
endmodule

/* rtl/kmr_core.sv */
// Event decode, layer state and report run builder.
module kmr_core (
   input  logic               clock,
   input  logic               reset,
   kmr_csr_if.sink            csr_ch,
   input  logic               item_valid,
   input  kmr_pkg::item_type  item,
   input  logic [7:0]         key_code,
   input  logic               can_load,
   output logic               take,
   output kmr_pkg::run_type   run
);
   import kmr_pkg::*;

   logic       arrows_ff;
   logic [7:0] step_ff;
   logic       meta_ff, meta_in, touch_ff, touch_in;
   logic       octrl_ff, octrl_in, oalt_ff, oalt_in;
   logic [7:0] level_ff, level_in, saved_ff, saved_in;

   // configuration registers
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         arrows_ff <= 1'b0;
         step_ff   <= 8'd16;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ARROWS: arrows_ff <= csr_ch.data[0];
            CSR_STEP:   step_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // build the report run of the held item
   always_comb begin
      report_type [MAX_REPORTS-1:0] rs;
      logic [RUN_CW-1:0] n;
      logic press, done, use_ctrl;
      logic [7:0] kk, r;
      rs = '0;
      n = '0;
      meta_in = meta_ff;
      touch_in = touch_ff;
      octrl_in = octrl_ff;
      oalt_in = oalt_ff;
      level_in = level_ff;
      saved_in = saved_ff;
      press = item.key_phase == ST_PRESSED;
      done = 1'b0;
      use_ctrl = item.ctrl_held || octrl_ff;
      kk = key_code;
      r = 8'd0;
      if (item.operation == OP_KEY &&
          (item.key_phase == ST_PRESSED || item.key_phase == ST_RELEASED)) begin
         rs[n] = mk_report(RK_SCAN, item.scancode, 8'd0); n = n + 1'b1;
         if (key_code != 8'd0 && key_code != K_UNKNOWN) begin
            if (arrows_ff && key_code == K_COMPOSE) begin
               kk = K_ENTER;
            end else if (!meta_ff && key_code == K_COMPOSE) begin
               if (!press) meta_in = 1'b1;
               done = 1'b1;
            end else if (key_code == K_PROPS) begin
               if (press) begin
                  rs[n] = mk_report(RK_KEY, K_LCTRL, 8'd1); n = n + 1'b1;
                  rs[n] = mk_report(RK_KEY, K_PREFIX, 8'd1); n = n + 1'b1;
                  rs[n] = mk_report(RK_KEY, K_PREFIX, 8'd0); n = n + 1'b1;
                  rs[n] = mk_report(RK_KEY, K_LCTRL, 8'd0); n = n + 1'b1;
               end
               done = 1'b1;
            end
            if (!done && !arrows_ff && meta_ff) begin
               if (kk == K_Q || kk == K_A || kk == K_X || kk == K_C || kk == K_N ||
                   kk == K_M || kk == K_MUTE || kk == K_COMPOSE) begin
                  // single-function keys act on release
                  if (!press) begin
                     priority case (kk)
                        K_Q, K_A: begin
                           r = (kk == K_Q) ? K_LEFT : K_RIGHT;
                           rs[n] = mk_report(RK_KEY, K_LALT, 8'd1); n = n + 1'b1;
                           rs[n] = mk_report(RK_KEY, r, 8'd1); n = n + 1'b1;
                           rs[n] = mk_report(RK_KEY, r, 8'd0); n = n + 1'b1;
                           rs[n] = mk_report(RK_KEY, K_LALT, 8'd0); n = n + 1'b1;
                        end
                        K_X, K_C: begin
                           if (kk == K_X) octrl_in = 1'b1;
                           else oalt_in = 1'b1;
                           meta_in = 1'b0;
                           touch_in = 1'b0;
                           rs[n] = mk_report(RK_TOUCH, 8'd0, 8'd0); n = n + 1'b1;
                        end
                        K_COMPOSE: begin
                           if (touch_ff) begin
                              rs[n] = mk_report(RK_KEY, K_ENTER, 8'd1); n = n + 1'b1;
                              rs[n] = mk_report(RK_KEY, K_ENTER, 8'd0); n = n + 1'b1;
                           end else begin
                              touch_in = 1'b1;
                              rs[n] = mk_report(RK_TOUCH, 8'd0, 8'd1); n = n + 1'b1;
                           end
                        end
                        K_N: begin
                           level_in = (level_ff < step_ff) ? 8'd0 : level_ff - step_ff;
                           rs[n] = mk_report(RK_LIGHT, 8'd0, level_in); n = n + 1'b1;
                        end
                        K_M: begin
                           level_in = (level_ff > LEVEL_MAX - step_ff) ? LEVEL_MAX
                                      : level_ff + step_ff;
                           rs[n] = mk_report(RK_LIGHT, 8'd0, level_in); n = n + 1'b1;
                        end
                        default: begin
                           // mute toggles the backlight against the saved level
                           if (saved_ff != 8'd0) begin
                              level_in = saved_ff;
                              saved_in = 8'd0;
                           end else begin
                              saved_in = level_ff;
                              level_in = 8'd0;
                           end
                           rs[n] = mk_report(RK_LIGHT, 8'd0, level_in); n = n + 1'b1;
                           meta_in = 1'b0;
                        end
                     endcase
                  end
               end else begin
                  // navigation keys stay in the layer, others leave it
                  priority case (kk)
                     K_E: r = K_UP;
                     K_S: r = K_DOWN;
                     K_W: r = K_LEFT;
                     K_D: r = K_RIGHT;
                     K_R: r = K_HOME;
                     K_F: r = K_END;
                     K_O: r = K_PGUP;
                     K_P: r = K_PGDN;
                     default: begin
                        r = (kk == K_T) ? K_TAB : ((kk == K_ESC) ? 8'd0 : kk);
                        meta_in = 1'b0;
                        touch_in = 1'b0;
                        rs[n] = mk_report(RK_TOUCH, 8'd0, 8'd0); n = n + 1'b1;
                     end
                  endcase
                  if (r != 8'd0) begin
                     rs[n] = mk_report(RK_KEY, r, {7'd0, press}); n = n + 1'b1;
                     if (!meta_in && r != kk) begin
                        rs[n] = mk_report(RK_KEY, r, 8'd0); n = n + 1'b1;
                     end
                  end
               end
            end else if (!done) begin
               // plain key wrapped in modifiers
               if (item.shift_held) begin
                  rs[n] = mk_report(RK_KEY, K_LSHIFT, 8'd1); n = n + 1'b1;
               end
               if (use_ctrl) begin
                  rs[n] = mk_report(RK_KEY, K_LCTRL, 8'd1); n = n + 1'b1;
               end
               if (oalt_ff) begin
                  rs[n] = mk_report(RK_KEY, K_LALT, 8'd1); n = n + 1'b1;
               end
               if (item.altgr_held) begin
                  rs[n] = mk_report(RK_KEY, K_RALT, 8'd1); n = n + 1'b1;
               end
               rs[n] = mk_report(RK_KEY, kk, {7'd0, press}); n = n + 1'b1;
               if (item.shift_held) begin
                  rs[n] = mk_report(RK_KEY, K_LSHIFT, 8'd0); n = n + 1'b1;
               end
               if (use_ctrl) begin
                  rs[n] = mk_report(RK_KEY, K_LCTRL, 8'd0); n = n + 1'b1;
                  octrl_in = 1'b0;
               end
               if (oalt_ff) begin
                  rs[n] = mk_report(RK_KEY, K_LALT, 8'd0); n = n + 1'b1;
                  oalt_in = 1'b0;
               end
               if (item.altgr_held) begin
                  rs[n] = mk_report(RK_KEY, K_RALT, 8'd0); n = n + 1'b1;
               end
            end
         end
      end else if (item.operation == OP_MOTION && (arrows_ff || touch_ff)) begin
         // trackpad deltas past the dead zone become arrow taps
         if (arrows_ff && (item.motion_x < -MOTION_DEAD || item.motion_x > MOTION_DEAD)) begin
            r = (item.motion_x < -MOTION_DEAD) ? K_LEFT : K_RIGHT;
            rs[n] = mk_report(RK_KEY, r, 8'd1); n = n + 1'b1;
            rs[n] = mk_report(RK_KEY, r, 8'd0); n = n + 1'b1;
         end
         if (item.motion_y < -MOTION_DEAD || item.motion_y > MOTION_DEAD) begin
            r = (item.motion_y < -MOTION_DEAD) ? K_UP : K_DOWN;
            rs[n] = mk_report(RK_KEY, r, 8'd1); n = n + 1'b1;
            rs[n] = mk_report(RK_KEY, r, 8'd0); n = n + 1'b1;
         end
      end
      run.reports = rs;
      run.count   = n;
   end

   assign take = item_valid && (run.count == '0 || can_load);

   // layer and backlight state advance as the item leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff  <= 1'b0;
         touch_ff <= 1'b0;
         octrl_ff <= 1'b0;
         oalt_ff  <= 1'b0;
         level_ff <= LEVEL_MAX;
         saved_ff <= LEVEL_MAX;
      end else if (take) begin
         meta_ff  <= meta_in;
         touch_ff <= touch_in;
         octrl_ff <= octrl_in;
         oalt_ff  <= oalt_in;
         level_ff <= level_in;
         saved_ff <= saved_in;
      end
   end
endmodule

/* rtl/kmr_emit.sv */
// Run buffer that sends one report word per cycle while the sink is ready.
module kmr_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  kmr_pkg::run_type  run,
   output logic              can_load,
   kmr_rsp_if.source         rsp_ch
);
   import kmr_pkg::*;

   report_type [MAX_REPORTS-1:0] buf_ff;
   logic [RUN_CW-1:0]            cnt_ff, pos_ff;
   logic                         busy_ff;
   logic                         last, last_acc;
   report_type                   cur;

   assign cur      = buf_ff[pos_ff];
   assign last     = pos_ff == cnt_ff - 1'b1;
   assign last_acc = busy_ff && rsp_ch.ready && last;
   assign can_load = !busy_ff || last_acc;

   assign rsp_ch.valid        = busy_ff;
   assign rsp_ch.report_kind  = cur.kind;
   assign rsp_ch.report_code  = cur.code;
   assign rsp_ch.report_value = cur.value;
   assign rsp_ch.run_end      = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (take && run.count != '0) begin
         busy_ff <= 1'b1;
         pos_ff  <= '0;
      end else if (last_acc) begin
         busy_ff <= 1'b0;
      end else if (busy_ff && rsp_ch.ready) begin
         pos_ff <= pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && run.count != '0) begin
         buf_ff <= run.reports;
         cnt_ff <= run.count;
      end
   end
endmodule

/* rtl/keyboard_meta_layer_remapper_top.sv */
// Top level of the keyboard meta layer remapper.
//
//   channel   dir  words
//   req_ch    in   key event, trackpad motion or keymap write
//   rsp_ch    out  one report per word, run_end on the last of an item's run
//   csr_ch    in   register write: index 0 arrows mode, 1 backlight step
//
// An item reaches the decode stage in the cycle after accept (keymap read port);
// its run is registered into the emit buffer as it is taken. Reports leave one per
// cycle while rsp_ch is ready; items with no report are taken without waiting.
// Reset clears layer state and sets backlight to full; the keymap is not cleared.
// A stalled output holds the decode stage, and the input stalls behind it.
module keyboard_meta_layer_remapper_top (
   input  logic       clock,
   input  logic       reset,
   kmr_req_if.sink    req_ch,
   kmr_rsp_if.source  rsp_ch,
   kmr_csr_if.sink    csr_ch
);
   import kmr_pkg::*;

   logic       item_valid, take, can_load;
   item_type   item;
   logic [7:0] key_code;
   run_type    run;

   kmr_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .take(take),
      .item_valid(item_valid), .item(item), .key_code(key_code)
   );

   kmr_core u_core (
      .clock(clock), .reset(reset), .csr_ch(csr_ch), .item_valid(item_valid),
      .item(item), .key_code(key_code), .can_load(can_load), .take(take), .run(run)
   );

   kmr_emit u_emit (
      .clock(clock), .reset(reset), .take(take), .run(run),
      .can_load(can_load), .rsp_ch(rsp_ch)
   );
endmodule

/* tb/sv/tb_keyboard_meta_layer_remapper_top.sv */
// Testbench for the keyboard meta layer remapper: directed and random traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_keyboard_meta_layer_remapper_top;
   import kmr_pkg::*;

   typedef struct {
      logic [1:0]        operation;
      logic [1:0]        key_phase;
      logic [7:0]        scancode;
      logic              shift_held;
      logic              ctrl_held;
      logic              altgr_held;
      logic signed [7:0] motion_x;
      logic signed [7:0] motion_y;
      logic [7:0]        map_entry;
   } event_t;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] code;
      logic [7:0] value;
      logic       last;
   } report_t;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_HELD     = 2'd2;
   localparam int         STALL_LIMIT = 3000;
   localparam int         N_KEYS      = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kmr_req_if req_ch ();
   kmr_rsp_if rsp_ch ();
   kmr_csr_if csr_ch ();

   keyboard_meta_layer_remapper_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // pending words, expected reports, bookkeeping
   event_t  pend_q[$];
   report_t report_q[$];
   report_t run_q[$];
   int      issued_n   = 0;
   int      accepted_n = 0;
   int      error_n    = 0;
   bit      quiet      = 1'b0;
   bit      req_took   = 1'b0;
   bit      csr_took   = 1'b0;
   int      req_gap    = 0;
   int      rsp_gap    = 0;
   int      stall_n    = 0;

   // scancodes of the keys of interest
   logic [7:0] key_sc[N_KEYS];
   logic [7:0] written_sc[$];

   // predictor state
   logic       p_arrows;
   logic [7:0] p_step;
   logic       p_meta, p_touch, p_octrl, p_oalt;
   logic [7:0] p_level, p_saved;
   logic [7:0] p_table[KEYMAP_DEPTH];

   function automatic void emit(logic [1:0] kind, logic [7:0] code, logic [7:0] value);
      report_t r;
      r.kind = kind; r.code = code; r.value = value; r.last = 1'b0;
      run_q.push_back(r);
   endfunction

   function automatic void tap(logic [7:0] code);
      emit(RK_KEY, code, 8'd1);
      emit(RK_KEY, code, 8'd0);
   endfunction

   function automatic void chord(logic [7:0] modk, logic [7:0] code);
      emit(RK_KEY, modk, 8'd1);
      tap(code);
      emit(RK_KEY, modk, 8'd0);
   endfunction

   function automatic void leave_meta();
      p_meta = 1'b0;
      emit(RK_TOUCH, 8'd0, 8'd0);
      p_touch = 1'b0;
   endfunction

   // meta layer single-function keys, acting on release
   function automatic void meta_function(logic [7:0] k);
      case (k)
         K_Q: chord(K_LALT, K_LEFT);
         K_A: chord(K_LALT, K_RIGHT);
         K_X: begin p_octrl = 1'b1; leave_meta(); end
         K_C: begin p_oalt = 1'b1; leave_meta(); end
         K_COMPOSE: begin
            if (p_touch) tap(K_ENTER);
            else begin emit(RK_TOUCH, 8'd0, 8'd1); p_touch = 1'b1; end
         end
         K_N: begin
            p_level = (p_level < p_step) ? 8'd0 : p_level - p_step;
            emit(RK_LIGHT, 8'd0, p_level);
         end
         K_M: begin
            p_level = (p_level > LEVEL_MAX - p_step) ? LEVEL_MAX : p_level + p_step;
            emit(RK_LIGHT, 8'd0, p_level);
         end
         K_MUTE: begin
            if (p_saved != 0) begin p_level = p_saved; p_saved = 8'd0; end
            else begin p_saved = p_level; p_level = 8'd0; end
            emit(RK_LIGHT, 8'd0, p_level);
            p_meta = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] meta_nav(logic [7:0] k);
      case (k)
         K_E: return K_UP;
         K_S: return K_DOWN;
         K_W: return K_LEFT;
         K_D: return K_RIGHT;
         K_R: return K_HOME;
         K_F: return K_END;
         K_O: return K_PGUP;
         K_P: return K_PGDN;
         K_T: begin leave_meta(); return K_TAB; end
         K_ESC: begin leave_meta(); return 8'd0; end
         default: begin leave_meta(); return k; end
      endcase
   endfunction

   function automatic void predict_key(event_t e);
      logic       press;
      logic       use_ctrl;
      logic [7:0] k;
      logic [7:0] r;
      press = (e.key_phase == ST_PRESSED);
      if (e.key_phase != ST_PRESSED && e.key_phase != ST_RELEASED) return;
      emit(RK_SCAN, e.scancode, 8'd0);
      k = p_table[e.scancode];
      if (k == 0 || k == K_UNKNOWN) return;
      if (p_arrows && k == K_COMPOSE) begin
         k = K_ENTER;
      end else if (!p_meta && k == K_COMPOSE) begin
         if (!press) p_meta = 1'b1;
         return;
      end else if (k == K_PROPS) begin
         if (press) chord(K_LCTRL, K_PREFIX);
         return;
      end
      if (!p_arrows && p_meta) begin
         if (k inside {K_Q, K_A, K_X, K_C, K_N, K_M, K_MUTE, K_COMPOSE}) begin
            if (!press) meta_function(k);
            return;
         end
         r = meta_nav(k);
         if (r == 0) return;
         emit(RK_KEY, r, {7'd0, press});
         if (!p_meta && r != k) emit(RK_KEY, r, 8'd0);
         return;
      end
      // plain path: wrap in modifiers
      use_ctrl = e.ctrl_held || p_octrl;
      if (e.shift_held) emit(RK_KEY, K_LSHIFT, 8'd1);
      if (use_ctrl) emit(RK_KEY, K_LCTRL, 8'd1);
      if (p_oalt) emit(RK_KEY, K_LALT, 8'd1);
      if (e.altgr_held) emit(RK_KEY, K_RALT, 8'd1);
      emit(RK_KEY, k, {7'd0, press});
      if (e.shift_held) emit(RK_KEY, K_LSHIFT, 8'd0);
      if (use_ctrl) begin emit(RK_KEY, K_LCTRL, 8'd0); p_octrl = 1'b0; end
      if (p_oalt) begin emit(RK_KEY, K_LALT, 8'd0); p_oalt = 1'b0; end
      if (e.altgr_held) emit(RK_KEY, K_RALT, 8'd0);
   endfunction

   function automatic void predict_motion(event_t e);
      if (p_arrows) begin
         if (e.motion_x < -MOTION_DEAD) tap(K_LEFT);
         else if (e.motion_x > MOTION_DEAD) tap(K_RIGHT);
      end else if (!p_touch) begin
         return;
      end
      if (e.motion_y < -MOTION_DEAD) tap(K_UP);
      else if (e.motion_y > MOTION_DEAD) tap(K_DOWN);
   endfunction

   // expected reports of one accepted word
   function automatic void predict_reports(event_t e);
      run_q.delete();
      case (e.operation)
         OP_KEY:    predict_key(e);
         OP_MOTION: predict_motion(e);
         OP_WRITE:  p_table[e.scancode] = e.map_entry;
         default:   ;
      endcase
      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
      foreach (run_q[i]) report_q.push_back(run_q[i]);
   endfunction

   // accept, predict, check, watchdog
   always @(posedge clock) begin
      report_t x;
      req_took = req_ch.valid && req_ch.ready && !reset;
      csr_took = csr_ch.valid && csr_ch.ready && !reset;
      if (req_took) begin
         event_t e;
         e.operation = req_ch.operation;   e.key_phase  = req_ch.key_phase;
         e.scancode  = req_ch.scancode;    e.shift_held = req_ch.shift_held;
         e.ctrl_held = req_ch.ctrl_held;   e.altgr_held = req_ch.altgr_held;
         e.motion_x  = req_ch.motion_x;    e.motion_y   = req_ch.motion_y;
         e.map_entry = req_ch.map_entry;
         predict_reports(e);
         accepted_n++;
      end
      if (csr_took) begin
         if (csr_ch.index == CSR_ARROWS) p_arrows = csr_ch.data[0];
         else p_step = csr_ch.data;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (report_q.size() == 0) begin
            error_n++;
            if (error_n <= 10) $display("unexpected report kind %0d code %0d value %0d",
                                        rsp_ch.report_kind, rsp_ch.report_code,
                                        rsp_ch.report_value);
         end else begin
            x = report_q.pop_front();
            if (rsp_ch.report_kind !== x.kind || rsp_ch.report_code !== x.code ||
                rsp_ch.report_value !== x.value || rsp_ch.run_end !== x.last) begin
               error_n++;
               if (error_n <= 10)
                  $display("mismatch exp kind %0d code %0d value %0d end %0d, got %0d %0d %0d %0d",
                           x.kind, x.code, x.value, x.last, rsp_ch.report_kind,
                           rsp_ch.report_code, rsp_ch.report_value, rsp_ch.run_end);
            end
         end
      end
      if (reset || req_took || csr_took || (rsp_ch.valid && rsp_ch.ready)) stall_n = 0;
      else stall_n++;
      if (stall_n >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // request driver with idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_took) begin
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pend_q.size() > 0) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(0, 15);
               req_ch.valid <= 1'b0;
            end else begin
               event_t e;
               e = pend_q.pop_front();
               req_ch.operation  <= e.operation;  req_ch.key_phase  <= e.key_phase;
               req_ch.scancode   <= e.scancode;   req_ch.shift_held <= e.shift_held;
               req_ch.ctrl_held  <= e.ctrl_held;  req_ch.altgr_held <= e.altgr_held;
               req_ch.motion_x   <= e.motion_x;   req_ch.motion_y   <= e.motion_y;
               req_ch.map_entry  <= e.map_entry;
               req_ch.valid <= 1'b1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // report sink stalls in bursts
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         rsp_gap = $urandom_range(0, 15);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic void add_word(logic [1:0] op, logic [1:0] st, logic [7:0] sc,
                                    logic [2:0] mods, logic signed [7:0] mx,
                                    logic signed [7:0] my, logic [7:0] ent);
      event_t e;
      e.operation = op; e.key_phase = st; e.scancode = sc;
      e.shift_held = mods[2]; e.ctrl_held = mods[1]; e.altgr_held = mods[0];
      e.motion_x = mx; e.motion_y = my; e.map_entry = ent;
      if (op == OP_WRITE) written_sc.push_back(sc);
      pend_q.push_back(e);
      issued_n++;
   endfunction

   function automatic void add_tap(logic [7:0] sc, logic [2:0] mods);
      add_word(OP_KEY, ST_PRESSED, sc, mods, 8'sd0, 8'sd0, 8'd0);
      add_word(OP_KEY, ST_RELEASED, sc, mods, 8'sd0, 8'sd0, 8'd0);
   endfunction

   function automatic logic signed [7:0] rand_delta();
      case ($urandom_range(0, 5))
         0: return -8'sd128;
         1: return 8'sd127;
         2: return 8'($urandom_range(0, 10) - 5);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // random words: mostly meta sequences, then plain keys, motion, writes, noise
   function automatic void add_random(int n);
      int start, i, j;
      start = issued_n;
      while (issued_n - start < n) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               add_tap(key_sc[2], 3'($urandom_range(0, 7)));
               for (j = $urandom_range(1, 3); j > 0; j--) begin
                  i = $urandom_range(0, N_KEYS - 1);
                  add_tap(key_sc[i], 3'($urandom_range(0, 7)));
                  if ($urandom_range(0, 2) == 0)
                     add_word(OP_MOTION, 2'd0, 8'd0, 3'd0, rand_delta(), rand_delta(), 8'd0);
               end
            end
            4, 5: begin
               i = $urandom_range(0, written_sc.size() - 1);
               add_word(OP_KEY, $urandom_range(0, 1) ? ST_PRESSED : ST_RELEASED,
                        written_sc[i], 3'($urandom_range(0, 7)), 8'sd0, 8'sd0, 8'd0);
            end
            6, 7: begin
               add_word(OP_MOTION, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        3'($urandom_range(0, 7)), rand_delta(), rand_delta(),
                        8'($urandom_range(0, 255)));
            end
            8: begin
               add_word(OP_WRITE, 2'($urandom_range(0, 3)), 8'($urandom_range(230, 254)),
                        3'd0, 8'sd0, 8'sd0, 8'($urandom_range(0, 255)));
            end
            default: begin
               // ignored words: unused operation or idle/held state
               i = $urandom_range(0, written_sc.size() - 1);
               if ($urandom_range(0, 1))
                  add_word(OP_UNUSED, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           3'($urandom_range(0, 7)), rand_delta(), rand_delta(), 8'd0);
               else
                  add_word(OP_KEY, $urandom_range(0, 1) ? ST_IDLE : ST_HELD,
                           written_sc[i], 3'd7, 8'sd0, 8'sd0, 8'd0);
            end
         endcase
      end
   endfunction

   task automatic drain();
      while (accepted_n != issued_n || report_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [7:0] value);
      @(negedge clock);
      csr_ch.index = idx;
      csr_ch.data  = value;
      csr_ch.valid = 1'b1;
      do @(negedge clock); while (!csr_took);
      csr_ch.valid = 1'b0;
   endtask

   initial begin
      logic [7:0] codes[N_KEYS];
      codes = '{K_UNKNOWN, 8'd0, K_COMPOSE, K_PROPS, K_Q, K_A, K_X, K_C, K_N, K_M,
                K_MUTE, K_E, K_S, K_W, K_D, K_R, K_F, K_O, K_P, K_T, K_ESC,
                8'd255, K_LEFT, 8'd48};
      req_ch.valid = 1'b0;     req_ch.operation = OP_KEY; req_ch.key_phase = ST_IDLE;
      req_ch.scancode = 8'd0;  req_ch.shift_held = 1'b0;  req_ch.ctrl_held = 1'b0;
      req_ch.altgr_held = 1'b0; req_ch.motion_x = 8'sd0;  req_ch.motion_y = 8'sd0;
      req_ch.map_entry = 8'd0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.index = CSR_ARROWS; csr_ch.data = 8'd0;
      p_arrows = 1'b0; p_step = 8'd16;
      p_meta = 1'b0; p_touch = 1'b0; p_octrl = 1'b0; p_oalt = 1'b0;
      p_level = LEVEL_MAX; p_saved = LEVEL_MAX;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // load the keymap; scancodes 0 and 255 at the ends
      for (int i = 0; i < N_KEYS; i++) begin
         key_sc[i] = (i == 0) ? 8'd0 : (i == N_KEYS - 1) ? 8'd255 : 8'(i * 9 + 3);
         add_word(OP_WRITE, ST_PRESSED, key_sc[i], 3'd0, 8'sd0, 8'sd0, codes[i]);
      end
      drain();

      // directed: plain key with all modifiers, meta entry, touch keys, motion extremes
      add_tap(key_sc[22], 3'd7);
      add_tap(key_sc[3], 3'd0);
      add_tap(key_sc[2], 3'd0);
      add_tap(key_sc[2], 3'd0);
      add_word(OP_MOTION, ST_IDLE, 8'd0, 3'd0, -8'sd128, 8'sd127, 8'd0);
      add_word(OP_MOTION, ST_IDLE, 8'd0, 3'd0, 8'sd5, -8'sd5, 8'd0);
      add_tap(key_sc[2], 3'd0);
      add_tap(key_sc[20], 3'd0);
      add_word(OP_UNUSED, ST_HELD, 8'd255, 3'd7, 8'sd127, -8'sd128, 8'd255);
      add_word(OP_KEY, ST_HELD, key_sc[22], 3'd0, 8'sd0, 8'sd0, 8'd0);
      drain();

      // arrows mode, largest step
      csr_write(CSR_ARROWS, 8'd1);
      csr_write(CSR_STEP, 8'd255);
      add_random(20);
      drain();

      // meta mode, saturating step
      csr_write(CSR_ARROWS, 8'd0);
      add_random(25);
      drain();

      // zero step, then unit step with no idling
      csr_write(CSR_STEP, 8'd0);
      add_random(15);
      drain();
      csr_write(CSR_STEP, 8'd1);
      csr_write(CSR_ARROWS, 8'hfe);
      quiet = 1'b1;
      add_random(20);
      drain();
      repeat (20) @(negedge clock);

      if (error_n == 0 && report_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
